### sv/cba_pkg.sv
// Shared types, widths and status codes of the contiguous block allocator.
package cba_pkg;

  localparam int OFF_W   = 16;
  localparam int LEN_W   = 17;
  localparam int DEF_MAX_REGIONS = 16;

  localparam logic [LEN_W-1:0] POOL_LIMIT = LEN_W'(1) << OFF_W;
  localparam logic [LEN_W-1:0] POOL_RESET = LEN_W'(65536);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] len;
  } cba_entry_t;

  typedef enum logic {
    FIT_AFTER,
    FIT_GAP
  } cba_mode_t;

  typedef struct packed {
    logic             fit;
    logic             match;
    logic [LEN_W-1:0] end_val;
  } cba_fit_t;

endpackage

### sv/cba_region_mem.sv
// Region table memory: one write port, one read port with registered data.
module cba_region_mem
  import cba_pkg::*;
#(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  localparam int IW = $clog2(MAX_REGIONS)
) (
  input  logic       clk,
  input  logic       wr_en,
  input  logic [IW-1:0] wr_addr,
  input  cba_entry_t wr_data,
  input  logic [IW-1:0] rd_addr,
  output cba_entry_t rd_data
);

  cba_entry_t mem [MAX_REGIONS];
  cba_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/cba_fit_unit.sv
// Shared fit unit: region end, subtract-and-compare fit test, offset match.
module cba_fit_unit
  import cba_pkg::*;
(
  input  cba_mode_t        mode,
  input  cba_entry_t       entry,
  input  logic [LEN_W-1:0] pool_eff,
  input  logic [LEN_W-1:0] prev_end,
  input  logic [LEN_W-1:0] size,
  input  logic [OFF_W-1:0] offset,
  output cba_fit_t         res
);

  logic [LEN_W-1:0] end_val;
  logic [LEN_W-1:0] op_a;
  logic [LEN_W-1:0] op_b;
  logic [LEN_W-1:0] diff;

  always_comb begin
    end_val = LEN_W'(entry.start) + entry.len;
    // after-last: room between the last end and the pool end
    // gap: room between the previous end and this start
    if (mode == FIT_AFTER) begin
      op_a = pool_eff;
      op_b = end_val;
    end else begin
      op_a = LEN_W'(entry.start);
      op_b = prev_end;
    end
    diff        = op_a - op_b;
    res.fit     = (op_a >= op_b) && (diff >= size);
    res.match   = (entry.start == offset);
    res.end_val = end_val;
  end

endmodule

### sv/contiguous_block_allocator_top.sv
// Contiguous block allocator: sequencer, region table and shared fit unit.
//
// Usage:
//   Input channel (in_valid/in_stall): one request per transfer. in_action 0
//   allocates in_request_size bytes, 1 frees the region at in_free_offset.
//   Result channel (out_valid/out_stall): one result per request with the
//   status, the placed offset (zero unless an allocate succeeds) and the
//   bytes in use after the request.
//   Config channel (cfg_valid/cfg_ready): writes pool_bytes; cfg_ready is
//   always high. Write it only while no request is in flight.
// Operation: allocation reads the last region, scans the sorted table for a
//   gap and shifts the tail up one entry per cycle; a free scans for the
//   offset and shifts the tail down. The region table has one read port and
//   one write port, and the block takes one request at a time (in_stall
//   high while it works).
// The next request is taken while a finished result still waits in the
//   output register; a stalled receiver holds that result and blocks only
//   the completion of the following request.
// Reset: empty table, nothing in use, pool of 65536 bytes; the table needs
//   no clearing pass since only entries below the count are ever read.
module contiguous_block_allocator_top
  import cba_pkg::*;
#(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [LEN_W-1:0] in_request_size,
  input  logic [OFF_W-1:0] in_free_offset,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [OFF_W-1:0] out_region_offset,
  output logic [LEN_W-1:0] out_bytes_in_use,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_pool_bytes
);

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LAST, S_SCAN, S_SHUP, S_PUT, S_FIND, S_SHDN, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0] used_r, used_nxt;
  logic [LEN_W-1:0] pool_r, pool_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers, no reset
  logic             act_r, act_nxt;
  logic [LEN_W-1:0] size_r, size_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [IW-1:0]    addr_r, addr_nxt;
  logic [IW-1:0]    pos_r, pos_nxt;
  logic [LEN_W-1:0] prev_end_r, prev_end_nxt;
  logic [OFF_W-1:0] place_r, place_nxt;
  logic [1:0]       res_r, res_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [OFF_W-1:0] out_offset_r, out_offset_nxt;
  logic [LEN_W-1:0] out_used_r, out_used_nxt;

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  cba_entry_t       wr_data;
  cba_entry_t       rd_data;
  cba_fit_t         fit;
  cba_mode_t        mode;

  logic [LEN_W-1:0] pool_eff;
  logic [LEN_W-1:0] avail;
  logic [CW-1:0]    cnt_m1;
  logic [IW-1:0]    last_idx;
  logic             at_last;
  logic             in_xfer;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_region_offset = out_offset_r;
  assign out_bytes_in_use  = out_used_r;

  // effective pool is capped at the offset space; shrinking below use leaves no room
  assign pool_eff = (pool_r > POOL_LIMIT) ? POOL_LIMIT : pool_r;
  assign avail    = (used_r >= pool_eff) ? '0 : pool_eff - used_r;
  assign cnt_m1   = cnt_r - CW'(1);
  assign last_idx = cnt_m1[IW-1:0];
  assign at_last  = (addr_r == last_idx);
  assign mode     = (state_r == S_LAST) ? FIT_AFTER : FIT_GAP;

  cba_region_mem #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(addr_nxt),
    .rd_data(rd_data)
  );

  cba_fit_unit u_fit (
    .mode    (mode),
    .entry   (rd_data),
    .pool_eff(pool_eff),
    .prev_end(prev_end_r),
    .size    (size_r),
    .offset  (off_r),
    .res     (fit)
  );

  // Read data always reflects the entry at addr_r: the memory samples addr_nxt.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    used_nxt       = used_r;
    pool_nxt       = pool_r;
    out_valid_nxt  = out_valid_r;
    act_nxt        = act_r;
    size_nxt       = size_r;
    off_nxt        = off_r;
    addr_nxt       = addr_r;
    pos_nxt        = pos_r;
    prev_end_nxt   = prev_end_r;
    place_nxt      = place_r;
    res_nxt        = res_r;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_used_nxt   = out_used_r;
    wr_en          = 1'b0;
    wr_addr        = addr_r + IW'(1);
    wr_data        = rd_data;

    if (cfg_valid && cfg_ready) begin
      pool_nxt = cfg_pool_bytes;
    end

    // drop the held result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt   = in_action;
          size_nxt  = in_request_size;
          off_nxt   = in_free_offset;
          place_nxt = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (act_r == ACT_ALLOC) begin
          if ((size_r == '0) || (size_r > avail)) begin
            res_nxt   = ST_NOSPACE;
            state_nxt = S_DONE;
          end else if (cnt_r == CW'(MAX_REGIONS)) begin
            res_nxt   = ST_FULL;
            state_nxt = S_DONE;
          end else if (cnt_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_PUT;
          end else begin
            addr_nxt  = last_idx;
            state_nxt = S_LAST;
          end
        end else begin
          if (cnt_r == '0) begin
            res_nxt   = ST_NOTFOUND;
            state_nxt = S_DONE;
          end else begin
            addr_nxt  = '0;
            state_nxt = S_FIND;
          end
        end
      end
      S_LAST: begin
        if (fit.fit) begin
          place_nxt = fit.end_val[OFF_W-1:0];
          pos_nxt   = cnt_r[IW-1:0];
          state_nxt = S_PUT;
        end else begin
          prev_end_nxt = '0;
          addr_nxt     = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (fit.fit) begin
          // first entry with a zero previous end covers the slot before the first region
          place_nxt = prev_end_r[OFF_W-1:0];
          pos_nxt   = addr_r;
          addr_nxt  = last_idx;
          state_nxt = S_SHUP;
        end else if (at_last) begin
          res_nxt   = ST_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          prev_end_nxt = fit.end_val;
          addr_nxt     = addr_r + IW'(1);
        end
      end
      S_SHUP: begin
        // move the tail up one slot, last entry first
        wr_en   = 1'b1;
        wr_addr = addr_r + IW'(1);
        if (addr_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          addr_nxt = addr_r - IW'(1);
        end
      end
      S_PUT: begin
        wr_en         = 1'b1;
        wr_addr       = pos_r;
        wr_data.start = place_r;
        wr_data.len   = size_r;
        cnt_nxt       = cnt_r + CW'(1);
        used_nxt      = used_r + size_r;
        res_nxt       = ST_OK;
        state_nxt     = S_DONE;
      end
      S_FIND: begin
        if (fit.match) begin
          used_nxt = (used_r >= rd_data.len) ? used_r - rd_data.len : '0;
          res_nxt  = ST_OK;
          if (at_last) begin
            cnt_nxt   = cnt_m1;
            state_nxt = S_DONE;
          end else begin
            addr_nxt  = addr_r + IW'(1);
            state_nxt = S_SHDN;
          end
        end else if (at_last) begin
          res_nxt   = ST_NOTFOUND;
          state_nxt = S_DONE;
        end else begin
          addr_nxt = addr_r + IW'(1);
        end
      end
      S_SHDN: begin
        // close the hole left by the freed region
        wr_en   = 1'b1;
        wr_addr = addr_r - IW'(1);
        if (at_last) begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_DONE;
        end else begin
          addr_nxt = addr_r + IW'(1);
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_offset_nxt = (res_r == ST_OK) ? place_r : '0;
          out_used_nxt   = used_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      used_r      <= '0;
      pool_r      <= POOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      pool_r      <= pool_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    size_r       <= size_nxt;
    off_r        <= off_nxt;
    addr_r       <= addr_nxt;
    pos_r        <= pos_nxt;
    prev_end_r   <= prev_end_nxt;
    place_r      <= place_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_used_r   <= out_used_nxt;
  end

endmodule

### sv/cba_checker.sv
// Port-level checks of the contiguous block allocator, bound to the top level.
module cba_checker
  import cba_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       out_status,
  input logic [OFF_W-1:0] out_region_offset,
  input logic [LEN_W-1:0] out_bytes_in_use
);

  // a failed request never reports a placement
  a_fail_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_region_offset == '0)
    else $error("failed request carries a nonzero offset");

  // bytes in use never exceed the offset space
  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes_in_use <= POOL_LIMIT)
    else $error("bytes in use beyond the offset space");

  // a full table holds regions of at least one byte each
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_bytes_in_use != '0)
    else $error("table full reported with nothing in use");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_region_offset) && $stable(out_bytes_in_use))
    else $error("stalled result changed");

endmodule

bind contiguous_block_allocator_top cba_checker u_cba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_region_offset(out_region_offset),
  .out_bytes_in_use (out_bytes_in_use)
);
